// ===== sv/vsp_pkg.sv =====
// ----------------------------------------------------------------------------
// vsp_pkg - view sphere projection shared types and constants
// Fixed-point formats, register indexes, tag structs and the arctangent table.
// ----------------------------------------------------------------------------
package vsp_pkg;

    localparam int ANG_W = 31;
    localparam int CW    = 43;
    localparam int ACC_W = 33;
    localparam int DVD_W = 56;
    localparam int DVS_W = 64;

    localparam logic [ANG_W-1:0] ANG_PI_2       = 31'h6487ED51;
    localparam logic [31:0]      OFF_VIEW_PIXEL = 32'h0BB80000;

    localparam logic [1:0] REG_VIEW_CENTER_Z   = 2'd0;
    localparam logic [1:0] REG_PIXEL_ANGLE_RAD = 2'd1;
    localparam logic [1:0] REG_LENS_CURVE      = 2'd2;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_sgn;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        t_sgn        sx;
        t_sgn        sy;
        logic        inview;
    } t_front;

    typedef struct packed {
        logic [31:0] rad;
        t_sgn        sy;
        logic        inview;
    } t_cytag;

    typedef struct packed {
        t_sgn sx;
        logic dvz;
    } t_dxtag;

    typedef struct packed {
        t_sgn sy;
        logic dvz;
        logic inview;
    } t_dytag;

    function automatic logic [ANG_W-1:0] f_atan(input logic [4:0] i);
        logic [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 31'd843314857;
            5'd1:    a = 31'd497837829;
            5'd2:    a = 31'd263043837;
            5'd3:    a = 31'd133525159;
            5'd4:    a = 31'd67021687;
            5'd5:    a = 31'd33543516;
            5'd6:    a = 31'd16775851;
            5'd7:    a = 31'd8388437;
            5'd8:    a = 31'd4194283;
            5'd9:    a = 31'd2097149;
            5'd10:   a = 31'd1048576;
            5'd11:   a = 31'd524288;
            5'd12:   a = 31'd262144;
            5'd13:   a = 31'd131072;
            5'd14:   a = 31'd65536;
            5'd15:   a = 31'd32768;
            5'd16:   a = 31'd16384;
            5'd17:   a = 31'd8192;
            5'd18:   a = 31'd4096;
            5'd19:   a = 31'd2048;
            5'd20:   a = 31'd1024;
            5'd21:   a = 31'd512;
            5'd22:   a = 31'd256;
            5'd23:   a = 31'd128;
            5'd24:   a = 31'd64;
            5'd25:   a = 31'd32;
            5'd26:   a = 31'd16;
            5'd27:   a = 31'd8;
            5'd28:   a = 31'd4;
            5'd29:   a = 31'd2;
            5'd30:   a = 31'd1;
            5'd31:   a = 31'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/vsp_if.sv =====
// ----------------------------------------------------------------------------
// vsp_if - point and pixel stream channels
// Valid/ready channels carrying one point or one pixel per beat.
// ----------------------------------------------------------------------------
interface vsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic               in_view;

    modport source (output valid, pixel_x, pixel_y, in_view, input ready);
    modport sink (input valid, pixel_x, pixel_y, in_view, output ready);
endinterface

// ===== sv/view_sphere_point_to_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// view_sphere_point_to_pixel_unit - 3-D point to view sphere pixel
// Maps a Q16.16 point to a Q16.16 pixel pair with an APB register port.
// ----------------------------------------------------------------------------
// One point enters per clock while no output beat waits, and its pixel passes
// through four front stages (input, magnitudes, squares, sum), 32 square root stages,
// CORDIC_STEPS + 3 CORDIC stages, one multiply stage, 56 divider stages and
// the output register. The whole pipeline holds while an output beat waits.
// Registers: 0x0 view_center_z, 0x4 pixel_angle_rad, 0x8 lens_curve.
module view_sphere_point_to_pixel_unit import vsp_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vsp_in_if.sink        i_pt,
    vsp_out_if.source     o_px,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int ISQ_N = 32;

    logic signed [31:0] r_vcz, r_pa, r_ln;
    logic               w_en;
    logic               r_out_vld;

    assign pready = 1'b1;
    assign w_en   = !r_out_vld || o_px.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcz <= 32'sd0;
            r_pa  <= 32'sd1144;
            r_ln  <= 32'sd65536;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_VIEW_CENTER_Z:   r_vcz <= pwdata;
                REG_PIXEL_ANGLE_RAD: r_pa  <= pwdata;
                REG_LENS_CURVE:      r_ln  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_VIEW_CENTER_Z:   prdata = r_vcz;
            REG_PIXEL_ANGLE_RAD: prdata = r_pa;
            REG_LENS_CURVE:      prdata = r_ln;
            default:             prdata = '0;
        endcase
    end

    logic [31:0] w_apa, w_aln;
    assign w_apa = r_pa[31] ? 32'(-r_pa) : 32'(r_pa);
    assign w_aln = r_ln[31] ? 32'(-r_ln) : 32'(r_ln);

    // front stages
    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [31:0] r1_x, r1_y, r1_z;
    t_front             r2_tag, r3_tag, r4_tag, n2_tag;
    logic [63:0]        r3_ay2, r3_az2, r4_sum;

    always_comb begin
        n2_tag.ax      = r1_x[31] ? 32'(-r1_x) : 32'(r1_x);
        n2_tag.ay      = r1_y[31] ? 32'(-r1_y) : 32'(r1_y);
        n2_tag.az      = r1_z[31] ? 32'(-r1_z) : 32'(r1_z);
        n2_tag.sx.zero = (r1_x == '0);
        n2_tag.sx.neg  = r1_x[31];
        n2_tag.sy.zero = (r1_y == '0) || (r_pa == '0) || (r_ln == '0);
        n2_tag.sy.neg  = r1_y[31] ^ r_pa[31] ^ r_ln[31];
        n2_tag.inview  = (r1_z < r_vcz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_pt.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x   <= i_pt.point_x;
            r1_y   <= i_pt.point_y;
            r1_z   <= i_pt.point_z;
            r2_tag <= n2_tag;
            r3_ay2 <= r2_tag.ay * r2_tag.ay;
            r3_az2 <= r2_tag.az * r2_tag.az;
            r3_tag <= r2_tag;
            r4_sum <= r3_ay2 + r3_az2;
            r4_tag <= r3_tag;
        end
    end

    // square root stages
    logic [63:0]      r_sv [ISQ_N];
    logic [63:0]      r_sr [ISQ_N];
    t_front           r_st [ISQ_N];
    logic [ISQ_N-1:0] r_svld;
    logic [63:0]      w_sv [ISQ_N];
    logic [63:0]      w_sr [ISQ_N];
    t_front           w_st [ISQ_N];
    logic [ISQ_N-1:0] w_svld;

    for (genvar gs = 0; gs < ISQ_N; gs++) begin : g_isq
        logic [63:0] w_bit, w_trial, n_sv, n_sr;
        logic        w_ge;

        if (gs == 0) begin : g_first
            assign w_sv[gs]   = r4_sum;
            assign w_sr[gs]   = '0;
            assign w_st[gs]   = r4_tag;
            assign w_svld[gs] = r4_vld;
        end else begin : g_next
            assign w_sv[gs]   = r_sv[gs-1];
            assign w_sr[gs]   = r_sr[gs-1];
            assign w_st[gs]   = r_st[gs-1];
            assign w_svld[gs] = r_svld[gs-1];
        end

        assign w_bit   = 64'd1 << (62 - 2 * gs);
        assign w_trial = w_sr[gs] + w_bit;
        assign w_ge    = (w_sv[gs] >= w_trial);
        assign n_sv    = w_ge ? w_sv[gs] - w_trial : w_sv[gs];
        assign n_sr    = w_ge ? (w_sr[gs] >> 1) + w_bit : (w_sr[gs] >> 1);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_svld[gs] <= 1'b0;
            end else if (w_en) begin
                r_svld[gs] <= w_svld[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sv[gs] <= n_sv;
                r_sr[gs] <= n_sr;
                r_st[gs] <= w_st[gs];
            end
        end
    end

    // angles
    t_front           w_fe;
    t_cytag           w_cy_in, w_cy_out;
    t_sgn             w_cx_out;
    logic             w_cx_vld, w_cy_vld;
    logic [ANG_W-1:0] w_thx, w_thy;

    assign w_fe            = r_st[ISQ_N-1];
    assign w_cy_in.rad     = r_sr[ISQ_N-1][31:0];
    assign w_cy_in.sy      = w_fe.sy;
    assign w_cy_in.inview  = w_fe.inview;

    vsp_cordic #(.STEPS(CORDIC_STEPS), .TW($bits(t_sgn))) u_cx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_svld[ISQ_N-1]),
        .i_den   (w_fe.az),
        .i_num   (w_fe.ax),
        .i_tag   (w_fe.sx),
        .o_vld   (w_cx_vld),
        .o_ang   (w_thx),
        .o_tag   (w_cx_out)
    );

    vsp_cordic #(.STEPS(CORDIC_STEPS), .TW($bits(t_cytag))) u_cy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_svld[ISQ_N-1]),
        .i_den   (w_fe.az),
        .i_num   (w_fe.ay),
        .i_tag   (w_cy_in),
        .o_vld   (w_cy_vld),
        .o_ang   (w_thy),
        .o_tag   (w_cy_out)
    );

    // multiply stage
    logic             rm_vld;
    logic [DVD_W-1:0] rm_dvd_x, rm_dvd_y;
    logic [DVS_W-1:0] rm_dvs_x, rm_dvs_y;
    t_dxtag           rm_tx;
    t_dytag           rm_ty;
    logic [37:0]      w_ny;

    assign w_ny = 38'(w_thy) * 38'd90;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else if (w_en) begin
            rm_vld <= w_cy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_dvd_x     <= {23'd0, w_thx, 2'b00};
            rm_dvd_y     <= {w_ny, 18'd0};
            rm_dvs_x     <= {32'd0, w_apa};
            rm_dvs_y     <= w_aln * w_cy_out.rad;
            rm_tx.sx     <= w_cx_out;
            rm_tx.dvz    <= (w_apa == '0);
            rm_ty.sy     <= w_cy_out.sy;
            rm_ty.dvz    <= (w_aln == '0) || (w_cy_out.rad == '0);
            rm_ty.inview <= w_cy_out.inview;
        end
    end

    // dividers
    logic             w_dx_vld, w_dy_vld;
    logic [DVD_W-1:0] w_qx, w_qy;
    t_dxtag           w_tx;
    t_dytag           w_ty;

    vsp_div #(.NW(DVD_W), .DW(DVS_W), .TW($bits(t_dxtag))) u_dx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (rm_vld),
        .i_dvd   (rm_dvd_x),
        .i_dvs   (rm_dvs_x),
        .i_tag   (rm_tx),
        .o_vld   (w_dx_vld),
        .o_quo   (w_qx),
        .o_tag   (w_tx)
    );

    vsp_div #(.NW(DVD_W), .DW(DVS_W), .TW($bits(t_dytag))) u_dy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (rm_vld),
        .i_dvd   (rm_dvd_y),
        .i_dvs   (rm_dvs_y),
        .i_tag   (rm_ty),
        .o_vld   (w_dy_vld),
        .o_quo   (w_qy),
        .o_tag   (w_ty)
    );

    function automatic logic [31:0] f_apply(input logic [DVD_W-1:0] m, input t_sgn s);
        logic [31:0] res;
        if (s.zero || (m == '0)) begin
            res = '0;
        end else if (!s.neg) begin
            res = (m > DVD_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : m[31:0];
        end else begin
            res = (m > DVD_W'(32'h80000000)) ? 32'h80000000 : 32'(-m[31:0]);
        end
        return res;
    endfunction

    // output register
    logic [31:0] r_pix_x, r_pix_y, n_pix_x, n_pix_y;
    logic        r_in_view;
    t_sgn        w_sx_eff;

    always_comb begin
        w_sx_eff      = w_tx.sx;
        w_sx_eff.zero = w_tx.sx.zero || w_tx.dvz;
        if (!w_ty.inview) begin
            n_pix_x = OFF_VIEW_PIXEL;
            n_pix_y = OFF_VIEW_PIXEL;
        end else begin
            n_pix_x = f_apply(w_qx, w_sx_eff);
            n_pix_y = w_ty.dvz ? 32'd0 : f_apply(w_qy, w_ty.sy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dy_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pix_x   <= n_pix_x;
            r_pix_y   <= n_pix_y;
            r_in_view <= w_ty.inview;
        end
    end

    assign o_px.valid   = r_out_vld;
    assign o_px.pixel_x = r_pix_x;
    assign o_px.pixel_y = r_pix_y;
    assign o_px.in_view = r_in_view;

`ifndef NO_ASSERTIONS
    a_cordic_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cx_vld == w_cy_vld) else $error("cordic lanes out of step");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dx_vld == w_dy_vld) else $error("divider lanes out of step");

    a_off_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && !o_px.in_view) |->
        (o_px.pixel_x == OFF_VIEW_PIXEL && o_px.pixel_y == OFF_VIEW_PIXEL))
        else $error("off-view beat with wrong pixel");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_px.valid && !o_px.ready) |-> !i_pt.ready)
        else $error("input taken while output beat stalled");
`endif

endmodule

// ===== sv/vsp_cordic.sv =====
// ----------------------------------------------------------------------------
// vsp_cordic - pipelined vectoring CORDIC
// Normalizes the operand pair, runs one rotation per stage and clamps the
// Q1.30 angle atan(num/den) to [0, pi/2].
// ----------------------------------------------------------------------------
module vsp_cordic import vsp_pkg::*; #(
    parameter int STEPS = 16,
    parameter int TW    = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [31:0]      i_den,
    input  logic [31:0]      i_num,
    input  logic [TW-1:0]    i_tag,
    output logic             o_vld,
    output logic [ANG_W-1:0] o_ang,
    output logic [TW-1:0]    o_tag
);

    function automatic logic [5:0] f_shift(input logic [31:0] v);
        logic [5:0] s;
        s = 6'd39;
        for (int k = 0; k < 32; k++) begin
            if (v[k]) begin
                s = 6'(39 - k);
            end
        end
        return s;
    endfunction

    logic             r0_vld, r1_vld;
    logic [31:0]      r0_den, r0_num;
    logic [5:0]       r0_sh;
    logic [TW-1:0]    r0_tag, r1_tag;
    logic signed [CW-1:0] r1_xa, r1_ya;
    logic             r1_nz, r1_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_vld;
            r1_vld <= r0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_den <= i_den;
            r0_num <= i_num;
            r0_sh  <= f_shift(i_den | i_num);
            r0_tag <= i_tag;
            r1_xa  <= $signed(CW'(r0_den) << r0_sh);
            r1_ya  <= $signed(CW'(r0_num) << r0_sh);
            r1_nz  <= (r0_num == '0);
            r1_dz  <= (r0_den == '0);
            r1_tag <= r0_tag;
        end
    end

    logic signed [CW-1:0]    r_xa [STEPS];
    logic signed [CW-1:0]    r_ya [STEPS];
    logic signed [ACC_W-1:0] r_ang [STEPS];
    logic [TW-1:0]           r_tag [STEPS];
    logic [STEPS-1:0]        r_vld, r_nz, r_dz;

    logic signed [CW-1:0]    w_xa [STEPS];
    logic signed [CW-1:0]    w_ya [STEPS];
    logic signed [ACC_W-1:0] w_ang [STEPS];
    logic [TW-1:0]           w_tag [STEPS];
    logic [STEPS-1:0]        w_vld, w_nz, w_dz;

    for (genvar gs = 0; gs < STEPS; gs++) begin : g_stage
        logic signed [CW-1:0]    n_xa, n_ya;
        logic signed [ACC_W-1:0] n_ang, w_at;
        logic                    w_pos;

        if (gs == 0) begin : g_first
            assign w_xa[gs]  = r1_xa;
            assign w_ya[gs]  = r1_ya;
            assign w_ang[gs] = '0;
            assign w_tag[gs] = r1_tag;
            assign w_vld[gs] = r1_vld;
            assign w_nz[gs]  = r1_nz;
            assign w_dz[gs]  = r1_dz;
        end else begin : g_next
            assign w_xa[gs]  = r_xa[gs-1];
            assign w_ya[gs]  = r_ya[gs-1];
            assign w_ang[gs] = r_ang[gs-1];
            assign w_tag[gs] = r_tag[gs-1];
            assign w_vld[gs] = r_vld[gs-1];
            assign w_nz[gs]  = r_nz[gs-1];
            assign w_dz[gs]  = r_dz[gs-1];
        end

        assign w_pos = !w_ya[gs][CW-1] && (w_ya[gs] != '0);
        assign w_at  = $signed({2'b00, f_atan(5'(gs))});
        assign n_xa  = w_pos ? w_xa[gs] + (w_ya[gs] >>> gs) : w_xa[gs] - (w_ya[gs] >>> gs);
        assign n_ya  = w_pos ? w_ya[gs] - (w_xa[gs] >>> gs) : w_ya[gs] + (w_xa[gs] >>> gs);
        assign n_ang = w_pos ? w_ang[gs] + w_at : w_ang[gs] - w_at;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= w_vld[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xa[gs]  <= n_xa;
                r_ya[gs]  <= n_ya;
                r_ang[gs] <= n_ang;
                r_tag[gs] <= w_tag[gs];
                r_nz[gs]  <= w_nz[gs];
                r_dz[gs]  <= w_dz[gs];
            end
        end
    end

    logic                    r_o_vld;
    logic [ANG_W-1:0]        r_o_ang, n_o_ang;
    logic [TW-1:0]           r_o_tag;
    logic signed [ACC_W-1:0] w_last;

    assign w_last = r_ang[STEPS-1];

    always_comb begin
        if (r_nz[STEPS-1]) begin
            n_o_ang = '0;
        end else if (r_dz[STEPS-1]) begin
            n_o_ang = ANG_PI_2;
        end else if (w_last[ACC_W-1]) begin
            n_o_ang = '0;
        end else if (w_last > $signed({2'b00, ANG_PI_2})) begin
            n_o_ang = ANG_PI_2;
        end else begin
            n_o_ang = w_last[ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_ang <= n_o_ang;
            r_o_tag <= r_tag[STEPS-1];
        end
    end

    assign o_vld = r_o_vld;
    assign o_ang = r_o_ang;
    assign o_tag = r_o_tag;

endmodule

// ===== sv/vsp_div.sv =====
// ----------------------------------------------------------------------------
// vsp_div - pipelined restoring divider
// One quotient bit per stage; a zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module vsp_div #(
    parameter int NW = 56,
    parameter int DW = 64,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_dvd,
    input  logic [DW-1:0] i_dvs,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_acc [NW];
    logic [DW-1:0] r_dvs [NW];
    logic [TW-1:0] r_tag [NW];
    logic [NW-1:0] r_vld;

    logic [DW-1:0] w_rem [NW];
    logic [NW-1:0] w_acc [NW];
    logic [DW-1:0] w_dvs [NW];
    logic [TW-1:0] w_tag [NW];
    logic [NW-1:0] w_vld;

    for (genvar gs = 0; gs < NW; gs++) begin : g_stage
        logic [DW:0]   w_part;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [DW:0]   w_diff;

        if (gs == 0) begin : g_first
            assign w_rem[gs] = '0;
            assign w_acc[gs] = i_dvd;
            assign w_dvs[gs] = i_dvs;
            assign w_tag[gs] = i_tag;
            assign w_vld[gs] = i_vld;
        end else begin : g_next
            assign w_rem[gs] = r_rem[gs-1];
            assign w_acc[gs] = r_acc[gs-1];
            assign w_dvs[gs] = r_dvs[gs-1];
            assign w_tag[gs] = r_tag[gs-1];
            assign w_vld[gs] = r_vld[gs-1];
        end

        assign w_part = {w_rem[gs], w_acc[gs][NW-1]};
        assign w_diff = w_part - {1'b0, w_dvs[gs]};
        assign w_ge   = (w_part >= {1'b0, w_dvs[gs]});
        assign n_rem  = w_ge ? w_diff[DW-1:0] : w_part[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= w_vld[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gs] <= n_rem;
                r_acc[gs] <= {w_acc[gs][NW-2:0], w_ge};
                r_dvs[gs] <= w_dvs[gs];
                r_tag[gs] <= w_tag[gs];
            end
        end
    end

    assign o_vld = r_vld[NW-1];
    assign o_quo = r_acc[NW-1];
    assign o_tag = r_tag[NW-1];

endmodule

// ===== dv/view_sphere_point_to_pixel_unit_test.sv =====
// ----------------------------------------------------------------------------
// view_sphere_point_to_pixel_unit_test - point to pixel projection testbench
// Drives points through the valid/ready channels and programs the registers
// over APB between phases. Every pixel beat is checked in order against a
// known edge row pixel or a bit-exact projection model in the testbench. A
// short table of edge points comes first, then random points under several
// register settings and three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module view_sphere_point_to_pixel_unit_test import vsp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STEPS        = 16;
    localparam int         IDLE_LIMIT   = 20000;
    localparam int         DRAIN_CYCLES = 150;
    localparam int         RAND_ITEMS   = 100;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               iv;
    } pixel_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 known;
        pixel_t             want;
    } point_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vsp_in_if  pt ();
    vsp_out_if px ();

    view_sphere_point_to_pixel_unit #(.CORDIC_STEPS(STEPS)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_px    (px),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [31:0] cfg_center_z;
    logic signed [31:0] cfg_pixel_angle;
    logic signed [31:0] cfg_lens;

    pixel_t pending_pixels[$];
    int     mismatches = 0;
    int     quiet_cycles = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        pt.valid   = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        px.ready   = 1'b0;
    end

    always @(negedge i_clk) begin
        px.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic longint atan_q30(int i);
        longint unsigned sum;
        longint unsigned term;
        int              k;
        if (i == 0) return 64'h3243F6A9;
        sum = 0;
        for (k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
            if (k & 1) sum -= term;
            else sum += term;
        end
        return longint'((sum + (64'd1 << 31)) >> 32);
    endfunction

    function automatic longint unsigned view_angle(longint unsigned adj, longint unsigned opp);
        longint xa;
        longint ya;
        longint ang;
        longint dx;
        longint dy;
        if (opp == 0) return 0;
        if (adj == 0) return longint'(ANG_PI_2);
        while ((adj | opp) < (64'd1 << 39)) begin
            adj = adj << 1;
            opp = opp << 1;
        end
        xa  = longint'(adj);
        ya  = longint'(opp);
        ang = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya > 0) begin
                xa += dx;
                ya -= dy;
                ang += atan_q30(i);
            end else begin
                xa -= dx;
                ya += dy;
                ang -= atan_q30(i);
            end
        end
        if (ang < 0) ang = 0;
        if (ang > longint'(ANG_PI_2)) ang = longint'(ANG_PI_2);
        return ang;
    endfunction

    function automatic longint unsigned radius_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int sign_of(logic signed [31:0] v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint unsigned mag_of(logic signed [31:0] v);
        return (v < 0) ? longint'(-longint'(v)) : longint'(v);
    endfunction

    function automatic logic signed [31:0] signed_sat(longint unsigned m, int s);
        if (s == 0 || m == 0) return '0;
        if (s > 0) return (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
        if (m > 64'h80000000) m = 64'h80000000;
        return -m[31:0];
    endfunction

    function automatic pixel_t project_point(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z);
        pixel_t          p;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        longint unsigned apa;
        longint unsigned aln;
        longint unsigned thx;
        longint unsigned thy;
        longint unsigned den;
        longint unsigned mx;
        longint unsigned my;
        if (!(z < cfg_center_z)) begin
            p.px = OFF_VIEW_PIXEL;
            p.py = OFF_VIEW_PIXEL;
            p.iv = 1'b0;
            return p;
        end
        ax  = mag_of(x);
        ay  = mag_of(y);
        az  = mag_of(z);
        apa = mag_of(cfg_pixel_angle);
        aln = mag_of(cfg_lens);
        thx = view_angle(az, ax);
        thy = view_angle(az, ay);
        mx  = (apa != 0) ? (thx * 4) / apa : 0;
        den = aln * radius_root(ay * ay + az * az);
        my  = (den != 0) ? (90 * thy * (64'd1 << 18)) / den : 0;
        p.px = signed_sat(mx, sign_of(x));
        p.py = signed_sat(my, sign_of(y) * sign_of(cfg_pixel_angle) * sign_of(cfg_lens));
        p.iv = 1'b1;
        return p;
    endfunction

    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n) begin
            if ((pt.valid && pt.ready) || (px.valid && px.ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (px.valid && px.ready) begin
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel beat px=%h py=%h iv=%b",
                                 px.pixel_x, px.pixel_y, px.in_view);
                end else begin
                    want = pending_pixels.pop_front();
                    if (px.pixel_x !== want.px || px.pixel_y !== want.py
                            || px.in_view !== want.iv) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pixel mismatch: exp %h %h %b got %h %h %b",
                                     want.px, want.py, want.iv,
                                     px.pixel_x, px.pixel_y, px.in_view);
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VIEW_CENTER_Z:   cfg_center_z = value;
            REG_PIXEL_ANGLE_RAD: cfg_pixel_angle = value;
            REG_LENS_CURVE:      cfg_lens = value;
            default: ;
        endcase
    endtask

    task automatic program_view(logic [31:0] cz, logic [31:0] pa, logic [31:0] ln);
        write_reg(REG_VIEW_CENTER_Z, cz);
        write_reg(REG_PIXEL_ANGLE_RAD, pa);
        write_reg(REG_LENS_CURVE, ln);
    endtask

    // call at a falling edge; returns at a falling edge with valid still high
    task automatic send_point(point_row_t r);
        while ($urandom_range(99) < snd_idle_pct) begin
            pt.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt.valid   <= 1'b1;
        pt.point_x <= r.x;
        pt.point_y <= r.y;
        pt.point_z <= r.z;
        do @(posedge i_clk); while (!(pt.valid && pt.ready));
        pending_pixels.push_back(r.known ? r.want : project_point(r.x, r.y, r.z));
        @(negedge i_clk);
    endtask

    task automatic drain_pixels();
        pt.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0, 1:    return $urandom;
            2:       return $urandom_range(2) == 0 ? 32'sh7FFFFFFF : 32'sh80000000;
            3:       return '0;
            4:       return $signed($urandom_range(32'h1FFFFF)) - 32'sh100000;
            default: return $signed({8'h0, 8'($urandom_range(255)), 16'h0}) - 32'sh800000;
        endcase
    endfunction

    function automatic point_row_t rand_point();
        point_row_t r;
        longint     zl;
        r.known = 1'b0;
        r.x     = rand_coord();
        r.y     = rand_coord();
        if ($urandom_range(9) < 7 && cfg_center_z != 32'sh80000000) begin
            case ($urandom_range(2))
                0:       zl = longint'(cfg_center_z) - 1 - $urandom_range(32'hFFFFF);
                1:       zl = longint'(cfg_center_z) - 1 - $urandom;
                default: zl = longint'(cfg_center_z) - 1;
            endcase
            if (zl < -64'sd2147483648) zl = -64'sd2147483648;
            r.z = zl[31:0];
        end else begin
            r.z = rand_coord();
        end
        return r;
    endfunction

    localparam pixel_t OFF_PIX = '{OFF_VIEW_PIXEL, OFF_VIEW_PIXEL, 1'b0};
    localparam pixel_t ZERO_PIX = '{32'sh0, 32'sh0, 1'b1};
    localparam pixel_t NO_PIX = '{32'sh0, 32'sh0, 1'b0};

    point_row_t edge_points[13] = '{
        '{32'sh0,        32'sh0,        32'sh0,        1'b1, OFF_PIX},
        '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, OFF_PIX},
        '{32'sh80000000, 32'sh7FFFFFFF, 32'sh1,        1'b1, OFF_PIX},
        '{32'sh0,        32'sh0,        -32'sh10000,   1'b1, ZERO_PIX},
        '{32'sh0,        32'sh0,        32'sh80000000, 1'b1, ZERO_PIX},
        '{32'sh10000,    32'sh10000,    -32'sh10000,   1'b0, NO_PIX},
        '{-32'sh10000,   -32'sh10000,   -32'sh10000,   1'b0, NO_PIX},
        '{32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh1,       1'b0, NO_PIX},
        '{32'sh80000000, 32'sh80000000, -32'sh1,       1'b0, NO_PIX},
        '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, NO_PIX},
        '{32'sh1,        -32'sh1,       32'sh80000000, 1'b0, NO_PIX},
        '{32'sh7FFFFFFF, 32'sh0,        -32'sh10000,   1'b0, NO_PIX},
        '{32'sh12345678, -32'sh12345678, 32'sh80000001, 1'b0, NO_PIX}
    };

    logic [31:0] view_cz[11] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h000A0000,
                                 32'h0, 32'hFFFB0000, 32'h1, 32'h40000000,
                                 32'h0, 32'h0, 32'h0};
    logic [31:0] view_pa[11] = '{32'd1144, 32'h10000, 32'h3A2B, 32'h0, -32'd1144,
                                 32'h80000000, 32'h7FFFFFFF, 32'h1, 32'h0, 32'h0,
                                 32'd1144};
    logic [31:0] view_ln[11] = '{32'h10000, 32'h30000, 32'hFFFF0000, -32'h10000,
                                 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h0,
                                 32'h0, 32'h10000};

    initial begin
        cfg_center_z    = 32'sh0;
        cfg_pixel_angle = 32'sd1144;
        cfg_lens        = 32'sh10000;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        snd_idle_pct = 28;
        rcv_idle_pct = 77;
        foreach (edge_points[i]) send_point(edge_points[i]);
        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 4) begin
                snd_idle_pct = 77;
                rcv_idle_pct = 28;
            end else if (ph == 8) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            drain_pixels();
            if (ph == 8 || ph == 9) begin
                program_view($urandom, $urandom, $urandom);
                write_reg(REG_UNUSED, $urandom);
            end else if (ph > 0) begin
                program_view(view_cz[ph], view_pa[ph], view_ln[ph]);
            end
            for (int n = 0; n < RAND_ITEMS; n++) send_point(rand_point());
        end
        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
